@@ hw/rtl/sccb_pkg.sv @@
// Shared types and constants for the SCCB register master.
package sccb_pkg;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WR_DEV = 1'b0,
        CFG_RD_DEV = 1'b1
    } t_cfg_idx;

    // Transaction phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_WBYTE = 3'd2,
        PH_STOP  = 3'd3,
        PH_RBYTE = 3'd4
    } t_phase;

    // Sub-step codes within a phase
    localparam logic [1:0] STEP_A = 2'd0;
    localparam logic [1:0] STEP_B = 2'd1;
    localparam logic [1:0] STEP_C = 2'd2;

    // Byte position within a transaction
    localparam logic [1:0] BYTE_ADDR = 2'd0;
    localparam logic [1:0] BYTE_REG  = 2'd1;
    localparam logic [1:0] BYTE_DATA = 2'd2;
    localparam logic [1:0] BYTE_END  = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] LAST_BIT      = 4'd7;

    localparam logic [7:0] WR_DEV_RESET = 8'h42;
    localparam logic [7:0] RD_DEV_RESET = 8'h43;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] reg_addr;
        logic [7:0] wr_value;
        logic       sda_in;
    } t_in_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_out_res;

    typedef struct packed {
        logic [7:0] wr_dev;
        logic [7:0] rd_dev;
    } t_dev_addr;

endpackage

@@ hw/rtl/sccb_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface sccb_in_if;
    import sccb_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);
endinterface

interface sccb_out_if;
    import sccb_pkg::*;
    logic     valid;
    logic     ready;
    t_out_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);
endinterface

@@ hw/rtl/sccb_cfg.sv @@
// Device address configuration registers.
module sccb_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  sccb_pkg::t_cfg_idx  i_idx,
    input  logic [7:0]          i_data,
    output sccb_pkg::t_dev_addr o_dev
);
    import sccb_pkg::*;

    t_dev_addr r_dev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev.wr_dev <= WR_DEV_RESET;
            r_dev.rd_dev <= RD_DEV_RESET;
        end else if (i_we) begin
            case (i_idx)
                CFG_WR_DEV: r_dev.wr_dev <= i_data;
                CFG_RD_DEV: r_dev.rd_dev <= i_data;
                default: ;
            endcase
        end
    end

    assign o_dev = r_dev;

endmodule

@@ hw/rtl/sccb_seq.sv @@
// Bus sequencer: transaction state and one pin step per request.
module sccb_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  sccb_pkg::t_in_req   i_req,
    input  sccb_pkg::t_dev_addr i_dev,
    output sccb_pkg::t_out_res  o_res
);
    import sccb_pkg::*;

    t_phase     r_phase, n_phase;
    logic [1:0] r_sub, n_sub;
    logic [3:0] r_bit, n_bit;
    logic [1:0] r_byte, n_byte;
    logic [7:0] r_tx, n_tx;
    logic [7:0] r_rx, n_rx;
    logic       r_is_read, n_is_read;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_val, n_val;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_oe, n_oe;
    logic       done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_sub     <= STEP_A;
            r_bit     <= '0;
            r_byte    <= BYTE_ADDR;
            r_tx      <= '0;
            r_rx      <= '0;
            r_is_read <= 1'b0;
            r_reg     <= '0;
            r_val     <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_oe      <= 1'b1;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_sub     <= n_sub;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_is_read <= n_is_read;
            r_reg     <= n_reg;
            r_val     <= n_val;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_oe      <= n_oe;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_sub     = r_sub;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_is_read = r_is_read;
        n_reg     = r_reg;
        n_val     = r_val;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_oe      = r_oe;
        done      = 1'b0;

        if (i_req.cmd == CMD_TICK) begin
            if (r_phase != PH_IDLE) begin
                case (r_phase)
                    PH_START: begin
                        if (r_sub == STEP_A) begin
                            n_sda = 1'b0;
                            n_sub = STEP_B;
                        end else if (r_sub == STEP_B) begin
                            n_scl = 1'b0;
                            n_sub = STEP_C;
                        end else begin
                            n_phase = PH_WBYTE;
                            n_sub   = STEP_A;
                            n_bit   = '0;
                        end
                    end
                    PH_WBYTE: begin
                        if (r_bit < BITS_PER_BYTE) begin
                            if (r_sub == STEP_A) begin
                                n_scl = 1'b0;
                                n_sda = r_tx[7];
                                n_sub = STEP_B;
                            end else begin
                                n_scl = 1'b1;
                                n_tx  = {r_tx[6:0], 1'b0};
                                n_bit = r_bit + 4'd1;
                                n_sub = STEP_A;
                            end
                        end else if (r_sub == STEP_A) begin
                            n_scl = 1'b0;
                            n_sub = STEP_B;
                        end else if (r_sub == STEP_B) begin
                            // ninth bit: release SDA, not checked
                            n_oe  = 1'b0;
                            n_scl = 1'b1;
                            n_sub = STEP_C;
                        end else begin
                            n_oe = 1'b1;
                            if (r_byte == BYTE_ADDR) begin
                                n_byte  = BYTE_REG;
                                n_tx    = r_reg;
                                n_phase = PH_WBYTE;
                                n_sub   = STEP_A;
                                n_bit   = '0;
                            end else if (r_byte == BYTE_REG && !r_is_read) begin
                                n_byte  = BYTE_DATA;
                                n_tx    = r_val;
                                n_phase = PH_WBYTE;
                                n_sub   = STEP_A;
                                n_bit   = '0;
                            end else if (r_is_read && r_byte != BYTE_REG) begin
                                // device read address sent: turn bus around
                                n_phase = PH_RBYTE;
                                n_sub   = STEP_C;
                                n_bit   = '0;
                                n_oe    = 1'b0;
                            end else begin
                                n_phase = PH_STOP;
                                n_sub   = STEP_A;
                                n_sda   = 1'b0;
                                n_scl   = 1'b0;
                            end
                        end
                    end
                    PH_RBYTE: begin
                        if (r_sub == STEP_C) begin
                            n_scl = 1'b0;
                            n_sub = STEP_A;
                        end else if (r_bit < BITS_PER_BYTE) begin
                            if (r_sub == STEP_A) begin
                                n_scl = 1'b1;
                                n_sub = STEP_B;
                            end else begin
                                n_rx  = {r_rx[6:0], i_req.sda_in};
                                n_scl = 1'b0;
                                if (r_bit == LAST_BIT) begin
                                    n_oe  = 1'b1;
                                    n_sda = 1'b1;
                                end
                                n_bit = r_bit + 4'd1;
                                n_sub = STEP_A;
                            end
                        end else if (r_sub == STEP_A) begin
                            n_scl = 1'b1;
                            n_sub = STEP_B;
                        end else begin
                            n_oe    = 1'b1;
                            n_byte  = BYTE_END;
                            n_phase = PH_STOP;
                            n_sub   = STEP_A;
                            n_sda   = 1'b0;
                            n_scl   = 1'b0;
                        end
                    end
                    PH_STOP: begin
                        if (r_sub == STEP_A) begin
                            n_scl = 1'b1;
                            n_sub = STEP_B;
                        end else if (r_is_read && r_byte == BYTE_REG) begin
                            // repeated start for the read phase
                            n_byte  = BYTE_DATA;
                            n_phase = PH_START;
                            n_sub   = STEP_A;
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_oe    = 1'b1;
                            n_tx    = i_dev.rd_dev;
                        end else begin
                            n_sda   = 1'b1;
                            n_phase = PH_IDLE;
                            n_sub   = STEP_A;
                            n_bit   = '0;
                            n_scl   = 1'b1;
                            n_oe    = 1'b1;
                            done    = 1'b1;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end else if ((i_req.cmd == CMD_WRITE || i_req.cmd == CMD_READ)
                     && r_phase == PH_IDLE) begin
            n_is_read = (i_req.cmd == CMD_READ);
            n_reg     = i_req.reg_addr;
            n_val     = i_req.wr_value;
            n_rx      = '0;
            n_byte    = BYTE_ADDR;
            n_bit     = '0;
            n_phase   = PH_START;
            n_sub     = STEP_A;
            n_scl     = 1'b1;
            n_sda     = 1'b1;
            n_oe      = 1'b1;
            n_tx      = i_dev.wr_dev;
        end

        o_res.scl_level = n_scl;
        o_res.sda_level = n_oe & n_sda;
        o_res.sda_drive = n_oe;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = done;
        o_res.read_data = (done && n_is_read) ? n_rx : 8'h00;
    end

endmodule

@@ hw/rtl/sccb_register_master_core.sv @@
// Top level of the SCCB camera-register master.
// SCCB register master, bit level. Each request carries a command: a tick
// (one half-period of the bus has elapsed), a register write or a register
// read. Every request yields exactly one result showing the SCL/SDA levels
// and SDA drive enable after that request, plus busy, done and the read byte
// (nonzero only with done after a read). Write or read commands that arrive
// while busy, and the reserved command code, leave the state untouched and
// repeat the outputs. A write takes start + 3 bytes + stop; a read takes start
// + 2 bytes + stop, a repeated start, the device read address, 8 sampled bits
// with SDA released, a driven 1 on the ninth bit, then stop. The device
// addresses (reset 0x42 write, 0x43 read) are written through the config port;
// the user must write them only while the block is idle; the block does not
// enforce it. Timing: a request passes an input register, then the sequencer
// computes its pin step into a result register; a new request is accepted
// every cycle unless results stall. The output register frees as soon as its
// result is taken; one stalled result plus one queued request can be held.
module sccb_register_master_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  sccb_pkg::t_cfg_idx i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    sccb_in_if.sink            i_req,
    sccb_out_if.source         o_res
);
    import sccb_pkg::*;

    t_dev_addr dev;
    t_out_res  seq_res;

    logic      r_in_vld;
    t_in_req   r_in;
    logic      r_out_vld;
    t_out_res  r_out;
    logic      adv;

    // move input stage into the result register
    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    sccb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_dev   (dev)
    );

    sccb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_req   (r_in),
        .i_dev   (dev),
        .o_res   (seq_res)
    );

endmodule

@@ hw/rtl/sccb_chk.sv @@
// Port-level checker for the SCCB register master, bound to the top level.
module sccb_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input sccb_pkg::t_out_res  i_res_payload
);
    import sccb_pkg::*;

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_payload))
        else $error("result changed while stalled");

    // completion leaves the bus idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_payload.done_res |-> !i_res_payload.busy_res)
        else $error("done while still busy");

    // idle bus: both lines high and driven
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_payload.busy_res |->
            i_res_payload.scl_level && i_res_payload.sda_level
            && i_res_payload.sda_drive)
        else $error("bus not idle-high while not busy");

    // released SDA reports low level
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_payload.sda_drive |-> !i_res_payload.sda_level)
        else $error("sda level set while released");

    // read byte only shows with done
    a_data_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_payload.read_data != 8'h00) |-> i_res_payload.done_res)
        else $error("read data without done");

endmodule

bind sccb_register_master_core sccb_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload)
);
